FILE: rtl/dpfp_pkg.sv
// Package for the delimited pose frame parser: frame constants, command and
// result types shared by the front, queue, back and the channel interfaces.
// No dependencies.
`timescale 1ns / 1ps

package dpfp_pkg;

    // Frame delimiters.
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Payload layout: six little-endian 32-bit words.
    localparam int PAYLOAD_BYTES = 24;
    localparam int NUM_WORDS     = PAYLOAD_BYTES / 4;
    localparam int POS_W         = $clog2(PAYLOAD_BYTES);

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Commands that the front hands to the back.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_STORE = 2'd1,
        OP_GOOD  = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic        frame_ok;
        logic [31:0] heading_bits;
        logic [31:0] pitch_bits;
        logic [31:0] roll_bits;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] rate_bits;
        logic [31:0] good_count;
        logic [31:0] bad_count;
    } result_t;

endpackage

FILE: rtl/dpfp_channels.sv
// Valid/ready channel interfaces for received bytes and result items.
// Depends on dpfp_pkg.
`timescale 1ns / 1ps

interface dpfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpfp_result_if;
    import dpfp_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dpfp_front.sv
// Front end: accepts received bytes, tracks the frame phase and turns each
// byte into a command for the back end. Depends on dpfp_pkg, dpfp_channels.
`timescale 1ns / 1ps

module dpfp_front (
    input  logic                clk,
    input  logic                rst_n,
    dpfp_byte_if.sink           byte_ch,
    input  logic                q_full,
    output logic                q_push,
    output dpfp_pkg::cmd_t      q_cmd
);
    import dpfp_pkg::*;

    typedef enum logic [4:0] {
        PH_HEAD_CR = 5'b00001,
        PH_HEAD_LF = 5'b00010,
        PH_DATA    = 5'b00100,
        PH_TAIL_LF = 5'b01000,
        PH_TAIL_CR = 5'b10000
    } phase_t;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES - 1);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accept;
    cmd_t             cmd;

    // A byte is taken whenever the queue has room for its command.
    assign byte_ch.ready = !q_full;
    assign accept        = byte_ch.valid && byte_ch.ready;

    // Classify the byte against the current phase.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cmd.op     = OP_NONE;
        cmd.data   = byte_ch.rx_byte;
        cmd.pos    = pos_reg;
        case (phase_reg)
            PH_HEAD_CR:
            begin
                if (byte_ch.rx_byte == BYTE_CR)
                    phase_next = PH_HEAD_LF;
            end
            PH_HEAD_LF:
            begin
                if (byte_ch.rx_byte == BYTE_LF)
                begin
                    pos_next   = '0;
                    phase_next = PH_DATA;
                end
                else if (byte_ch.rx_byte != BYTE_CR)
                begin
                    phase_next = PH_HEAD_CR;
                end
            end
            PH_DATA:
            begin
                cmd.op = OP_STORE;
                if (pos_reg == POS_LAST)
                begin
                    pos_next   = '0;
                    phase_next = PH_TAIL_LF;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            PH_TAIL_LF:
            begin
                if (byte_ch.rx_byte == BYTE_LF)
                begin
                    phase_next = PH_TAIL_CR;
                end
                else
                begin
                    cmd.op     = OP_BAD;
                    phase_next = (byte_ch.rx_byte == BYTE_CR) ? PH_HEAD_LF : PH_HEAD_CR;
                end
            end
            PH_TAIL_CR:
            begin
                phase_next = PH_HEAD_CR;
                cmd.op     = (byte_ch.rx_byte == BYTE_CR) ? OP_GOOD : OP_BAD;
            end
            default:
            begin
                pos_next   = '0;
                phase_next = PH_HEAD_CR;
            end
        endcase
    end

    assign q_push = accept && (cmd.op != OP_NONE);
    assign q_cmd  = cmd;

    // Phase and position advance on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD_CR;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    // The payload position stays inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
    else $error("payload position beyond the store");

endmodule

FILE: rtl/dpfp_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on dpfp_pkg.
`timescale 1ns / 1ps

module dpfp_queue #(
    parameter int DEPTH = dpfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dpfp_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           head_valid,
    output dpfp_pkg::cmd_t head_cmd,
    input  logic           pop
);
    import dpfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
    else $error("command pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
    else $error("command popped from an empty queue");

endmodule

FILE: rtl/dpfp_back.sv
// Back end: carries out queued commands, holds the payload store, latest
// words and frame counters, and drives the result register.
// Depends on dpfp_pkg, dpfp_channels.
`timescale 1ns / 1ps

module dpfp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  dpfp_pkg::cmd_t head_cmd,
    output logic           pop,
    dpfp_result_if.source  result_ch
);
    import dpfp_pkg::*;

    logic [7:0]  store_reg [PAYLOAD_BYTES];
    logic [31:0] words_reg [NUM_WORDS];
    logic [31:0] frame_words [NUM_WORDS];
    logic [31:0] good_reg, bad_reg;
    logic        out_valid_reg;
    result_t     out_reg, out_next;
    logic        out_free, is_result, load;

    // A result command waits until the output register can take it.
    assign out_free  = !out_valid_reg || result_ch.ready;
    assign is_result = (head_cmd.op == OP_GOOD) || (head_cmd.op == OP_BAD);
    assign pop       = head_valid && (!is_result || out_free);
    assign load      = pop && is_result;

    // Assemble the little-endian words from the payload store.
    always_comb
    begin
        for (int k = 0; k < NUM_WORDS; k++)
            frame_words[k] = {store_reg[4*k+3], store_reg[4*k+2],
                              store_reg[4*k+1], store_reg[4*k]};
    end

    // Build the next result item.
    always_comb
    begin
        out_next.frame_ok     = (head_cmd.op == OP_GOOD);
        out_next.heading_bits = out_next.frame_ok ? frame_words[0] : words_reg[0];
        out_next.pitch_bits   = out_next.frame_ok ? frame_words[1] : words_reg[1];
        out_next.roll_bits    = out_next.frame_ok ? frame_words[2] : words_reg[2];
        out_next.x_bits       = out_next.frame_ok ? frame_words[3] : words_reg[3];
        out_next.y_bits       = out_next.frame_ok ? frame_words[4] : words_reg[4];
        out_next.rate_bits    = out_next.frame_ok ? frame_words[5] : words_reg[5];
        out_next.good_count   = out_next.frame_ok ? good_reg + 32'd1 : good_reg;
        out_next.bad_count    = out_next.frame_ok ? bad_reg : bad_reg + 32'd1;
    end

    // Payload bytes land in the store without reset.
    always_ff @(posedge clk)
    begin
        if (pop && (head_cmd.op == OP_STORE))
            store_reg[head_cmd.pos] <= head_cmd.data;
    end

    // Latest words, counters and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
                words_reg[k] <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                if (head_cmd.op == OP_GOOD)
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                        words_reg[k] <= frame_words[k];
                end
                good_reg      <= out_next.good_count;
                bad_reg       <= out_next.bad_count;
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_reg;

    // A good frame bumps the good count by one and leaves the bad count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (head_cmd.op == OP_GOOD)) |=>
            (good_reg == $past(good_reg) + 32'd1) && (bad_reg == $past(bad_reg)))
    else $error("good frame did not advance the good count alone");

endmodule

FILE: rtl/delimited_pose_frame_parser.sv
// Delimited pose frame parser, top level: front end, command queue and back end.
// Throughput: one byte per cycle; the back end retires one queued command per cycle,
// unless a result stall holds it; results pass through the queue and result register.
// Result stalls back up into the command queue; bytes stall once it is full.
// Reset (rst_n, asynchronous, active low) clears phase, words, counters and queue.
// Depends on dpfp_pkg, dpfp_channels, dpfp_front, dpfp_queue, dpfp_back.
`timescale 1ns / 1ps

module delimited_pose_frame_parser #(
    parameter int QUEUE_DEPTH = dpfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dpfp_byte_if.sink     byte_ch,
    dpfp_result_if.source result_ch
);
    import dpfp_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic q_pop;

    // Byte classification.
    dpfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // Command queue between the two halves.
    dpfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop)
    );

    // Command execution and result output.
    dpfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .result_ch  (result_ch)
    );

endmodule

FILE: tb/sv/delimited_pose_frame_parser_tb.sv
// Testbench for the delimited pose frame parser: directed frames from a table, then
// random framed and broken byte streams, checked by a behavioral decoder or table rows.
// Depends on dpfp_pkg, dpfp_channels and the delimited_pose_frame_parser RTL.
`timescale 1ns / 1ps

module delimited_pose_frame_parser_tb;
    import dpfp_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int BYTE_TARGET   = 850;
    localparam int SHOW_LIMIT    = 10;

    // Where the decoder stands in the frame.
    typedef enum logic [2:0] {
        PH_HUNT_CR  = 3'd0,
        PH_HUNT_LF  = 3'd1,
        PH_PAYLOAD  = 3'd2,
        PH_TAIL_LF  = 3'd3,
        PH_TAIL_CR  = 3'd4
    } frame_phase_t;

    // One directed frame: leading bytes, a filled or ramped payload, tail bytes.
    typedef struct {
        int          n_lead;
        logic [31:0] lead;
        logic [7:0]  fill;
        bit          ramp;
        int          n_tail;
        logic [15:0] tail;
        bit          typed;
        result_t     want;
    } frame_row_t;

    logic clk;
    logic rst_n;

    dpfp_byte_if   byte_ch ();
    dpfp_result_if result_ch ();

    delimited_pose_frame_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    // Decoder state, in step with the block.
    frame_phase_t link_phase = PH_HUNT_CR;
    logic [7:0]   payload_buf [PAYLOAD_BYTES];
    int           payload_idx = 0;
    logic [31:0]  pose_words [NUM_WORDS];
    logic [31:0]  good_tally = '0;
    logic [31:0]  bad_tally = '0;

    result_t     pending_results [$];
    frame_row_t  dir_rows [$];
    result_t     pinned_result;
    bit          pin_pending = 1'b0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          error_count = 0;
    int          idle_cycles = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    logic [5:0]  stall_step = '0;

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Snapshot of the latest words and counters as one result item.
    function automatic result_t pose_report(input logic ok);
        result_t r;
        r.frame_ok     = ok;
        r.heading_bits = pose_words[0];
        r.pitch_bits   = pose_words[1];
        r.roll_bits    = pose_words[2];
        r.x_bits       = pose_words[3];
        r.y_bits       = pose_words[4];
        r.rate_bits    = pose_words[5];
        r.good_count   = good_tally;
        r.bad_count    = bad_tally;
        return r;
    endfunction

    // Advances the decoder by one byte; returns 1 when the byte closes a frame.
    function automatic bit parse_rx_byte(input logic [7:0] b, output result_t res);
        bit emitted;
        emitted = 1'b0;
        res = '0;
        case (link_phase)
            PH_HUNT_CR:
            begin
                if (b == BYTE_CR)
                    link_phase = PH_HUNT_LF;
            end
            PH_HUNT_LF:
            begin
                if (b == BYTE_LF)
                begin
                    payload_idx = 0;
                    link_phase = PH_PAYLOAD;
                end
                else if (b != BYTE_CR)
                    link_phase = PH_HUNT_CR;
            end
            PH_PAYLOAD:
            begin
                payload_buf[payload_idx] = b;
                payload_idx++;
                if (payload_idx >= PAYLOAD_BYTES)
                    link_phase = PH_TAIL_LF;
            end
            PH_TAIL_LF:
            begin
                if (b == BYTE_LF)
                    link_phase = PH_TAIL_CR;
                else
                begin
                    // A CR here may already be the next header.
                    bad_tally++;
                    link_phase = (b == BYTE_CR) ? PH_HUNT_LF : PH_HUNT_CR;
                    res = pose_report(1'b0);
                    emitted = 1'b1;
                end
            end
            PH_TAIL_CR:
            begin
                link_phase = PH_HUNT_CR;
                if (b == BYTE_CR)
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                        pose_words[k] = {payload_buf[4*k+3], payload_buf[4*k+2],
                                         payload_buf[4*k+1], payload_buf[4*k]};
                    good_tally++;
                    res = pose_report(1'b1);
                end
                else
                begin
                    bad_tally++;
                    res = pose_report(1'b0);
                end
                emitted = 1'b1;
            end
            default:
            begin
                payload_idx = 0;
                link_phase = PH_HUNT_CR;
            end
        endcase
        return emitted;
    endfunction

    // Expected item whose six words all hold the same value.
    function automatic result_t fixed_result(input logic ok, input logic [31:0] word,
                                             input logic [31:0] good, input logic [31:0] bad);
        result_t r;
        r.frame_ok     = ok;
        r.heading_bits = word;
        r.pitch_bits   = word;
        r.roll_bits    = word;
        r.x_bits       = word;
        r.y_bits       = word;
        r.rate_bits    = word;
        r.good_count   = good;
        r.bad_count    = bad;
        return r;
    endfunction

    function automatic frame_row_t make_row(input int n_lead, input logic [31:0] lead,
                                            input logic [7:0] fill, input bit ramp,
                                            input int n_tail, input logic [15:0] tail,
                                            input bit typed, input result_t want);
        frame_row_t row;
        row.n_lead = n_lead;
        row.lead   = lead;
        row.fill   = fill;
        row.ramp   = ramp;
        row.n_tail = n_tail;
        row.tail   = tail;
        row.typed  = typed;
        row.want   = want;
        return row;
    endfunction

    // Random byte that favors the delimiters and the extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return BYTE_CR;
            1:       return BYTE_LF;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Sends one byte in bursts with random gaps, then predicts its effect.
    task automatic push_byte(input logic [7:0] b);
        int      gap;
        result_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (parse_rx_byte(b, res))
        begin
            pending_results.push_back(pin_pending ? pinned_result : res);
            pin_pending = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Result receiver: ready follows a 16-bit mask that changes when the 6-bit step wraps.
    always @(posedge clk)
    begin
        if (stall_step == '0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_mask <= 16'hFFFF;
                1:       stall_mask <= 16'($urandom) | 16'h0001;
                default: stall_mask <= 16'h0001;
            endcase
        end
        stall_step <= stall_step + 1'b1;
        result_ch.ready <= stall_mask[stall_step[3:0]];
    end

    // Result checking and the watchdog.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= SHOW_LIMIT)
                        $display("unexpected result item: %h", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
                    check_field("heading_bits", want.heading_bits, got.heading_bits);
                    check_field("pitch_bits", want.pitch_bits, got.pitch_bits);
                    check_field("roll_bits", want.roll_bits, got.roll_bits);
                    check_field("x_bits", want.x_bits, got.x_bits);
                    check_field("y_bits", want.y_bits, got.y_bits);
                    check_field("rate_bits", want.rate_bits, got.rate_bits);
                    check_field("good_count", want.good_count, got.good_count);
                    check_field("bad_count", want.bad_count, got.bad_count);
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("delimited_pose_frame_parser test failed");
                $finish;
            end
        end
    end

    initial
    begin
        frame_row_t row;
        int         kind;
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        result_ch.ready = 1'b0;
        for (int k = 0; k < NUM_WORDS; k++)
            pose_words[k] = '0;

        // Directed frames: bad tail before any good frame, stray header byte,
        // repeated CR, tail CR that restarts the header, second tail mismatch.
        dir_rows.push_back(make_row(2, {16'h0, BYTE_LF, BYTE_CR}, 8'hFF, 1'b0,
                                    1, 16'h0055, 1'b1, fixed_result(1'b0, '0, 0, 1)));
        dir_rows.push_back(make_row(4, {BYTE_LF, BYTE_CR, 8'h33, BYTE_CR}, 8'h00, 1'b0,
                                    2, {BYTE_CR, BYTE_LF}, 1'b1,
                                    fixed_result(1'b1, '0, 1, 1)));
        dir_rows.push_back(make_row(4, {BYTE_LF, BYTE_CR, BYTE_CR, BYTE_CR}, 8'hFF, 1'b0,
                                    2, {BYTE_CR, BYTE_LF}, 1'b1,
                                    fixed_result(1'b1, 32'hFFFF_FFFF, 2, 1)));
        dir_rows.push_back(make_row(2, {16'h0, BYTE_LF, BYTE_CR}, 8'h10, 1'b1,
                                    1, {8'h00, BYTE_CR}, 1'b1,
                                    fixed_result(1'b0, 32'hFFFF_FFFF, 2, 2)));
        dir_rows.push_back(make_row(1, {24'h0, BYTE_LF}, 8'hE8, 1'b1,
                                    2, {BYTE_CR, BYTE_LF}, 1'b0, '0));
        dir_rows.push_back(make_row(2, {16'h0, BYTE_LF, BYTE_CR}, BYTE_CR, 1'b0,
                                    2, {BYTE_LF, BYTE_LF}, 1'b0, '0));
        dir_rows.push_back(make_row(3, {8'h0, BYTE_LF, BYTE_CR, BYTE_LF}, BYTE_LF, 1'b0,
                                    2, {BYTE_CR, BYTE_LF}, 1'b1,
                                    fixed_result(1'b1, {4{BYTE_LF}}, 4, 3)));
        dir_rows.push_back(make_row(2, {16'h0, BYTE_LF, BYTE_CR}, 8'h80, 1'b1,
                                    2, {8'h0C, BYTE_LF}, 1'b0, '0));
        dir_rows.push_back(make_row(2, {16'h0, BYTE_LF, BYTE_CR}, 8'h00, 1'b1,
                                    2, {BYTE_CR, BYTE_LF}, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            pin_pending   = row.typed;
            pinned_result = row.want;
            for (int i = 0; i < row.n_lead; i++)
                push_byte(row.lead[8*i +: 8]);
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                push_byte(row.ramp ? 8'(row.fill + i) : row.fill);
            for (int i = 0; i < row.n_tail; i++)
                push_byte(row.tail[8*i +: 8]);
        end
        pin_pending = 1'b0;

        // Random part: mostly well-formed frames, with noise and broken frames mixed in.
        while (bytes_sent < BYTE_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                repeat ($urandom_range(1, 6)) push_byte(pick_byte());
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    push_byte(8'($urandom));
                push_byte(BYTE_CR);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) push_byte(BYTE_CR);
                if (kind < 14)
                    push_byte(8'($urandom));
                else
                begin
                    push_byte(BYTE_LF);
                    repeat (PAYLOAD_BYTES) push_byte(pick_byte());
                    if (kind < 22)
                        push_byte(8'($urandom));
                    else if (kind < 28)
                        push_byte(BYTE_CR);
                    else
                    begin
                        push_byte(BYTE_LF);
                        push_byte((kind < 36) ? 8'($urandom) : BYTE_CR);
                    end
                end
            end
        end
        byte_ch.valid <= 1'b0;

        // Let every expected item arrive, then allow for stray late items.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("delimited_pose_frame_parser test passed");
        else
            $display("delimited_pose_frame_parser test failed");
        $finish;
    end

endmodule

FILE: delimited_pose_frame_parser.f
rtl/dpfp_pkg.sv
rtl/dpfp_channels.sv
rtl/dpfp_front.sv
rtl/dpfp_queue.sv
rtl/dpfp_back.sv
rtl/delimited_pose_frame_parser.sv
tb/sv/delimited_pose_frame_parser_tb.sv
